@@ design/wltf_pkg.sv @@
// ----------------------------------------------------------------------------
// wltf_pkg: shared widths and constants of the windowed linear trend forecaster
// Holds the payload and slope widths, clamp reset value and minimum fit count.
// ----------------------------------------------------------------------------
`default_nettype none

package wltf_pkg;

    // Sample, forecast and clamp register width
    localparam int SAMPLE_W = 16;

    // Least-squares slope is bounded by the full-scale sample span
    localparam int SLOPE_W = SAMPLE_W + 1;

    // Reset value of the forecast clamp register
    localparam logic [SAMPLE_W-1:0] MAX_FORECAST_RESET = 16'd500;

    // Fewest held samples that allow a line fit
    localparam int MIN_FIT_COUNT = 2;

endpackage : wltf_pkg

`default_nettype wire

@@ design/wltf_if.sv @@
// ----------------------------------------------------------------------------
// wltf_if: valid/ready channels of the windowed linear trend forecaster
// Sample input channel, result output channel and clamp register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface wltf_sample_if;
    logic                          valid;
    logic                          ready;
    logic [wltf_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface : wltf_sample_if

interface wltf_result_if;
    logic                          valid;
    logic                          ready;
    logic [wltf_pkg::SAMPLE_W-1:0] forecast;
    logic                          fitted;

    modport source (output valid, output forecast, output fitted, input ready);
    modport sink   (input valid, input forecast, input fitted, output ready);
endinterface : wltf_result_if

interface wltf_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [wltf_pkg::SAMPLE_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface : wltf_cfg_if

`default_nettype wire

@@ design/wltf_ram.sv @@
// ----------------------------------------------------------------------------
// wltf_ram: generic single-clock RAM, one write and one read port
// Read data is registered: it appears in the cycle after the read request.
// ----------------------------------------------------------------------------
`default_nettype none

module wltf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 10
) (
    input  wire                             i_clk,
    input  wire                             i_wr_en,
    input  wire  [$clog2(DEPTH)-1:0]        i_wr_addr,
    input  wire  [WIDTH-1:0]                i_wr_data,
    input  wire                             i_rd_en,
    input  wire  [$clog2(DEPTH)-1:0]        i_rd_addr,
    output logic [WIDTH-1:0]                o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule : wltf_ram

`default_nettype wire

@@ design/window_linear_trend_forecast_core.sv @@
// ----------------------------------------------------------------------------
// window_linear_trend_forecast_core: sliding-window least-squares forecaster
//
// Usage:
//   i_sample  - one 16-bit reading per beat. Every accepted beat yields exactly
//               one result beat on o_result, in order.
//   o_result  - forecast plus fitted flag. fitted = 0 means the reading was
//               passed through (fewer than two readings held so far).
//   i_cfg     - write of the max_forecast clamp; always ready. Write only
//               while the block is idle.
// Operation:
//   Fewer than two held: the reading goes to the output register with no
//   fit. Otherwise the ring walk (one RAM read a cycle) sums the held
//   readings, then the bit-serial divider (DVW bits wide, 26 for WINDOW =
//   10) runs for the slope and then for the intercept, and the clamped
//   forecast goes to the output register. One item is in flight;
//   i_sample.ready is high in the idle state, also while an earlier result
//   still waits in o_result.
// Reset: ring empty, write pointer zero, clamp 500; ring contents not cleared.
// Stall: hold the result until taken; a finished item waits until it is free.
// ----------------------------------------------------------------------------
`default_nettype none

module window_linear_trend_forecast_core #(
    parameter int WINDOW = 10
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    wltf_sample_if.sink     i_sample,
    wltf_result_if.source   o_result,
    wltf_cfg_if.sink        i_cfg
);

    localparam int SW    = wltf_pkg::SAMPLE_W;
    localparam int SLW   = wltf_pkg::SLOPE_W;
    // ring address and held-count widths
    localparam int AW    = $clog2(WINDOW);
    localparam int OW    = AW + 1;
    localparam int NW    = $clog2(WINDOW + 1);
    // bounds of the running sums over x = 0..n-1 and y < 2^SW
    localparam int SXW   = $clog2(WINDOW * (WINDOW - 1) / 2 + 1);
    localparam int SXXW  = $clog2((WINDOW - 1) * WINDOW * (2 * WINDOW - 1) / 6 + 1);
    localparam int SYW   = SW + NW;
    localparam int SXYW  = SW + SXW;
    localparam int XYW   = AW + SW;
    // divider magnitude width and signed working width
    localparam int DVW   = NW + SXYW;
    localparam int NUMW  = DVW + 1;
    localparam int CW    = $clog2(DVW);

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_PROD,
        S_DIFF,
        S_DIV,
        S_QUOT,
        S_SCALE,
        S_LOAD2,
        S_PRED,
        S_CLAMP,
        S_DONE
    } t_state;

    t_state r_state;

    // persistent state
    logic [AW-1:0]          r_wp;
    logic [NW-1:0]          r_count;
    logic [SW-1:0]          r_max_forecast;

    // walk over the held readings
    logic [AW-1:0]          r_rd_addr;
    logic [NW-1:0]          r_rd_k;
    logic                   r_acc_en;
    logic [AW-1:0]          r_acc_x;
    logic [SXW-1:0]         r_sx;
    logic [SXXW-1:0]        r_sxx;
    logic [SYW-1:0]         r_sy;
    logic [SXYW-1:0]        r_sxy;

    // products and fit terms
    logic [NW+SXXW-1:0]     r_p_nsxx;
    logic [2*SXW-1:0]       r_p_sxsx;
    logic [DVW-1:0]         r_p_nsxy;
    logic [DVW-1:0]         r_p_sxsy;
    logic signed [SLW-1:0]  r_slope;
    logic signed [SLW+SXW:0] r_prod2;
    logic signed [NUMW-1:0] r_icpt;
    logic signed [NUMW-1:0] r_pred;

    // bit-serial divider, shared by slope and intercept
    logic [DVW-1:0]         r_rem;
    logic [DVW-1:0]         r_quo;
    logic [DVW-1:0]         r_dvs;
    logic                   r_neg;
    logic [CW-1:0]          r_div_cnt;
    logic                   r_second;

    // held result and output register
    logic [SW-1:0]          r_res;
    logic                   r_res_fitted;
    logic                   r_out_valid;
    logic [SW-1:0]          r_out_forecast;
    logic                   r_out_fitted;

    // combinational next values
    logic                   n_accept;
    logic [AW-1:0]          n_wp;
    logic [NW-1:0]          n_count;
    logic [OW-1:0]          n_old_sum;
    logic [AW-1:0]          n_oldest;
    logic [AW-1:0]          n_rd_addr;
    logic                   n_rd_en;
    logic [SW-1:0]          n_rd_data;
    logic [XYW-1:0]         n_xy;
    logic [2*AW-1:0]        n_xx;
    logic signed [NUMW-1:0] n_den;
    logic signed [NUMW-1:0] n_num;
    logic signed [NUMW-1:0] n_num_mag;
    logic signed [NUMW-1:0] n_e;
    logic signed [NUMW-1:0] n_e_mag;
    logic [DVW:0]           n_shift;
    logic [DVW:0]           n_trial;
    logic signed [NUMW-1:0] n_q;
    logic signed [SLW+NW:0] n_sn;
    logic                   n_out_free;
    logic                   n_out_load;

    assign n_accept   = i_sample.valid && i_sample.ready;
    assign n_out_free = !r_out_valid || o_result.ready;
    assign n_out_load = (r_state == S_DONE) && n_out_free;

    // advance the write pointer and the held count with wrap/saturation
    assign n_wp    = (r_wp == AW'(WINDOW - 1)) ? '0 : r_wp + 1'b1;
    assign n_count = (r_count == NW'(WINDOW)) ? r_count : r_count + 1'b1;

    // oldest held slot after this write: (wp_next - count_next) mod WINDOW
    assign n_old_sum = OW'(n_wp) + OW'(WINDOW) - OW'(n_count);
    assign n_oldest  = (n_old_sum >= OW'(WINDOW)) ? AW'(n_old_sum - OW'(WINDOW))
                                                  : AW'(n_old_sum);

    assign n_rd_addr = (r_rd_addr == AW'(WINDOW - 1)) ? '0 : r_rd_addr + 1'b1;
    assign n_rd_en   = (r_state == S_READ) && (r_rd_k != r_count);

    wltf_ram #(
        .WIDTH (SW),
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (n_accept),
        .i_wr_addr (r_wp),
        .i_wr_data (i_sample.sample),
        .i_rd_en   (n_rd_en),
        .i_rd_addr (r_rd_addr),
        .o_rd_data (n_rd_data)
    );

    assign n_xy = XYW'(r_acc_x) * XYW'(n_rd_data);
    assign n_xx = (2*AW)'(r_acc_x) * (2*AW)'(r_acc_x);

    // den = n*Sxx - Sx^2, num = n*Sxy - Sx*Sy
    assign n_den     = signed'({1'b0, DVW'(r_p_nsxx)}) - signed'({1'b0, DVW'(r_p_sxsx)});
    assign n_num     = signed'({1'b0, r_p_nsxy}) - signed'({1'b0, r_p_sxsy});
    assign n_num_mag = n_num[NUMW-1] ? -n_num : n_num;

    // intercept dividend: Sy - slope*Sx
    assign n_e     = signed'(NUMW'(r_sy)) - NUMW'(r_prod2);
    assign n_e_mag = n_e[NUMW-1] ? -n_e : n_e;

    // one restoring step: shift in the next dividend bit, try the subtract
    assign n_shift = {r_rem, r_quo[DVW-1]};
    assign n_trial = n_shift - {1'b0, r_dvs};

    // apply the sign: truncation toward zero
    assign n_q  = r_neg ? -signed'({1'b0, r_quo}) : signed'({1'b0, r_quo});
    assign n_sn = r_slope * signed'({1'b0, r_count});

    assign i_sample.ready   = (r_state == S_IDLE);
    assign i_cfg.ready      = 1'b1;
    assign o_result.valid    = r_out_valid;
    assign o_result.forecast = r_out_forecast;
    assign o_result.fitted   = r_out_fitted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_wp           <= '0;
            r_count        <= '0;
            r_max_forecast <= wltf_pkg::MAX_FORECAST_RESET;
            r_acc_en       <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_max_forecast <= i_cfg.data;
            end

            // load a finished result, else drop the output beat once taken
            if (n_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_result.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        r_wp      <= n_wp;
                        r_count   <= n_count;
                        r_res     <= i_sample.sample;
                        r_res_fitted <= 1'b0;
                        r_rd_addr <= n_oldest;
                        r_rd_k    <= '0;
                        r_acc_en  <= 1'b0;
                        r_sx      <= '0;
                        r_sxx     <= '0;
                        r_sy      <= '0;
                        r_sxy     <= '0;
                        if (n_count < NW'(wltf_pkg::MIN_FIT_COUNT)) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end

                S_READ: begin
                    // issue one read a cycle, accumulate the previous one
                    if (r_acc_en) begin
                        r_sx  <= r_sx + SXW'(r_acc_x);
                        r_sxx <= r_sxx + SXXW'(n_xx);
                        r_sy  <= r_sy + SYW'(n_rd_data);
                        r_sxy <= r_sxy + SXYW'(n_xy);
                    end
                    if (n_rd_en) begin
                        r_rd_addr <= n_rd_addr;
                        r_rd_k    <= r_rd_k + 1'b1;
                        r_acc_x   <= AW'(r_rd_k);
                        r_acc_en  <= 1'b1;
                    end else begin
                        r_acc_en  <= 1'b0;
                        r_state   <= S_PROD;
                    end
                end

                S_PROD: begin
                    r_p_nsxx <= (NW+SXXW)'(r_count) * (NW+SXXW)'(r_sxx);
                    r_p_sxsx <= (2*SXW)'(r_sx) * (2*SXW)'(r_sx);
                    r_p_nsxy <= DVW'(r_count) * DVW'(r_sxy);
                    r_p_sxsy <= DVW'(r_sx) * DVW'(r_sy);
                    r_state  <= S_DIFF;
                end

                S_DIFF: begin
                    if (n_den[NUMW-1] || (n_den == '0)) begin
                        // degenerate fit: pass the reading through
                        r_state <= S_DONE;
                    end else begin
                        r_rem     <= '0;
                        r_quo     <= n_num_mag[DVW-1:0];
                        r_dvs     <= n_den[DVW-1:0];
                        r_neg     <= n_num[NUMW-1];
                        r_div_cnt <= '0;
                        r_second  <= 1'b0;
                        r_state   <= S_DIV;
                    end
                end

                S_DIV: begin
                    if (!n_trial[DVW]) begin
                        r_rem <= n_trial[DVW-1:0];
                    end else begin
                        r_rem <= n_shift[DVW-1:0];
                    end
                    r_quo     <= {r_quo[DVW-2:0], ~n_trial[DVW]};
                    r_div_cnt <= r_div_cnt + 1'b1;
                    if (r_div_cnt == CW'(DVW - 1)) begin
                        r_state <= S_QUOT;
                    end
                end

                S_QUOT: begin
                    if (!r_second) begin
                        // slope fits in SLW bits: its size is bounded by the sample span
                        r_slope <= SLW'(n_q);
                        r_state <= S_SCALE;
                    end else begin
                        r_icpt  <= n_q;
                        r_state <= S_PRED;
                    end
                end

                S_SCALE: begin
                    r_prod2 <= r_slope * signed'({1'b0, r_sx});
                    r_state <= S_LOAD2;
                end

                S_LOAD2: begin
                    r_rem     <= '0;
                    r_quo     <= n_e_mag[DVW-1:0];
                    r_dvs     <= DVW'(r_count);
                    r_neg     <= n_e[NUMW-1];
                    r_div_cnt <= '0;
                    r_second  <= 1'b1;
                    r_state   <= S_DIV;
                end

                S_PRED: begin
                    r_pred  <= NUMW'(n_sn) + r_icpt;
                    r_state <= S_CLAMP;
                end

                S_CLAMP: begin
                    priority if (r_pred[NUMW-1]) begin
                        r_res <= '0;
                    end else if (r_pred > signed'(NUMW'(r_max_forecast))) begin
                        r_res <= r_max_forecast;
                    end else begin
                        r_res <= r_pred[SW-1:0];
                    end
                    r_res_fitted <= 1'b1;
                    r_state      <= S_DONE;
                end

                S_DONE: begin
                    // hold until the output register is free
                    if (n_out_free) begin
                        r_out_forecast <= r_res;
                        r_out_fitted   <= r_res_fitted;
                        r_state        <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule : window_linear_trend_forecast_core

`default_nettype wire
